// File: sv/bdd_pkg.sv
// Shared widths, pipeline payload types and the 2^x fraction table for the box delta decoder.
`default_nettype none

package bdd_pkg;

  // Field widths of the stream items.
  localparam int COORD_W = 18;   // signed Q14.4 coordinates
  localparam int DELTA_W = 16;   // signed Q4.12 deltas

  // Internal widths, each sized to the range its value can reach.
  localparam int SIZE_W  = 20;   // anchor size or corner sum, Q.4
  localparam int SCL_W   = 34;   // delta times log2(e), Q.28
  localparam int PSH_W   = 36;   // shift delta times size, Q.16
  localparam int CTR_W   = 37;   // centre, Q.16
  localparam int EXP_W   = 5;    // integer part of the power of two, -12..11
  localparam int FRAC_W  = 16;   // fraction bits of the power of two
  localparam int MANT_W  = 31;   // 2^fraction mantissa, Q.30, below 2.0
  localparam int PROD_W  = 52;   // size times mantissa
  localparam int SHAMT_W = 5;    // rounding shift, 8..31
  localparam int HALF_W  = 44;   // half of the scaled size, Q.16
  localparam int SUM_W   = 45;   // corner before rounding, Q.16

  localparam int LOG2E_Q16 = 94548;
  localparam int COORD_MAX = 131071;
  localparam int COORD_MIN = -131072;

  // Payload after the first register stage.
  typedef struct packed {
    logic signed [SIZE_W-1:0]  w;
    logic signed [SIZE_W-1:0]  h;
    logic signed [SIZE_W-1:0]  sx;    // x1 + x2 + one pixel
    logic signed [SIZE_W-1:0]  sy;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [SCL_W-1:0]   tw;
    logic signed [SCL_W-1:0]   th;
  } st1_t;

  // Payload after the second register stage.
  typedef struct packed {
    logic signed [SIZE_W-1:0]  w;
    logic signed [SIZE_W-1:0]  h;
    logic signed [SIZE_W-1:0]  sx;
    logic signed [SIZE_W-1:0]  sy;
    logic signed [PSH_W-1:0]   dxw;
    logic signed [PSH_W-1:0]   dyh;
    logic signed [EXP_W-1:0]   iw;
    logic signed [EXP_W-1:0]   ih;
    logic [FRAC_W-1:0]         fw;
    logic [FRAC_W-1:0]         fh;
  } st2_t;

  // Payload of the mantissa stages.
  typedef struct packed {
    logic signed [CTR_W-1:0]   cx;
    logic signed [CTR_W-1:0]   cy;
    logic signed [SIZE_W-1:0]  w;
    logic signed [SIZE_W-1:0]  h;
    logic signed [EXP_W-1:0]   iw;
    logic signed [EXP_W-1:0]   ih;
    logic [FRAC_W-1:0]         fw;
    logic [FRAC_W-1:0]         fh;
    logic [MANT_W-1:0]         mw;
    logic [MANT_W-1:0]         mh;
  } mant_t;

  typedef struct packed {
    logic signed [CTR_W-1:0]   cx;
    logic signed [CTR_W-1:0]   cy;
    logic signed [PROD_W-1:0]  pw;
    logic signed [PROD_W-1:0]  ph;
    logic [SHAMT_W-1:0]        shw;
    logic [SHAMT_W-1:0]        shh;
  } prod_t;

  typedef struct packed {
    logic signed [CTR_W-1:0]   cx;
    logic signed [CTR_W-1:0]   cy;
    logic signed [HALF_W-1:0]  hw;
    logic signed [HALF_W-1:0]  hh;
  } half_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]   x1;
    logic signed [SUM_W-1:0]   y1;
    logic signed [SUM_W-1:0]   x2;
    logic signed [SUM_W-1:0]   y2;
  } sum_t;

  // 2^(2^-k) in Q.30 for fraction bit k.
  function automatic logic [MANT_W-1:0] pow2_frac(input int k);
    logic [MANT_W-1:0] t;
    case (k)
      1:       t = 31'd1518500250;
      2:       t = 31'd1276901417;
      3:       t = 31'd1170923762;
      4:       t = 31'd1121280436;
      5:       t = 31'd1097253708;
      6:       t = 31'd1085434106;
      7:       t = 31'd1079572136;
      8:       t = 31'd1076653033;
      9:       t = 31'd1075196443;
      10:      t = 31'd1074468888;
      11:      t = 31'd1074105294;
      12:      t = 31'd1073923544;
      13:      t = 31'd1073832680;
      14:      t = 31'd1073787251;
      15:      t = 31'd1073764537;
      16:      t = 31'd1073753181;
      default: t = 31'd1073741824;
    endcase
    return t;
  endfunction

  // One mantissa update: m * t in Q.30, rounded half up.
  function automatic logic [MANT_W-1:0] frac_step(input logic [MANT_W-1:0] m,
                                                  input logic [MANT_W-1:0] t);
    logic [2*MANT_W:0] p;
    p = (63'(m) * 63'(t)) + (63'd1 << 29);
    return p[MANT_W+29:30];
  endfunction

endpackage

`default_nettype wire

// File: sv/bdd_corner.sv
// Rounds one Q.16 corner to Q14.4 and clamps it to the coordinate range.
`default_nettype none

module bdd_corner (
  input  wire logic signed [bdd_pkg::SUM_W-1:0]   v,
  output logic signed [bdd_pkg::COORD_W-1:0]      coord,
  output logic                                    clamped
);
  import bdd_pkg::*;

  localparam int RND_W = SUM_W - 11;

  logic signed [SUM_W:0]   biased;
  logic signed [RND_W-1:0] rnd;

  always_comb begin
    biased = $signed({v[SUM_W-1], v}) + $signed((SUM_W+1)'(2048));
    rnd    = biased[SUM_W:12];
    if (rnd > COORD_MAX) begin
      coord   = COORD_W'(COORD_MAX);
      clamped = 1'b1;
    end else if (rnd < COORD_MIN) begin
      coord   = COORD_W'(COORD_MIN);
      clamped = 1'b1;
    end else begin
      coord   = rnd[COORD_W-1:0];
      clamped = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: sv/box_delta_decode.sv
// Top level of the anchor box delta decoder: a 22-stage pipeline from anchor and deltas to corners.
`default_nettype none

// Decodes one anchor box and its regression deltas into a predicted box per beat. The anchor
// width and height are the corner differences plus one pixel, the centre moves by delta times
// size, and each size is scaled by exp(delta), formed as 2^(delta*log2(e)) from a shifted
// integer power and a fraction mantissa built one fraction bit at a time. Corners come out in
// signed Q14.4, clamped to the coordinate range; out_tuser is set when any corner was clamped.
// The pipeline takes one beat every cycle while the output side does not stall, and its depth
// is set by the sixteen dependent multiply stages of the mantissa, one per fraction bit. A stall
// on the output holds each stage that cannot move, while empty stages ahead of it keep filling,
// so in_tready drops only when all 22 stages hold an item and the output beat is not being
// taken. There is no configuration and no state beyond the pipeline.

module box_delta_decode (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // anchor_x1[17:0], anchor_y1[35:18], anchor_x2[53:36], anchor_y2[71:54],
  // shift_x[87:72], shift_y[103:88], log_scale_w[119:104], log_scale_h[135:120]
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_x1[17:0], out_y1[35:18], out_x2[53:36], out_y2[71:54]
  output logic [71:0]       out_tdata,
  // saturated[0]
  output logic [0:0]        out_tuser
);
  import bdd_pkg::*;

  // Stage positions in the valid vector.
  localparam int ST_S1   = 0;
  localparam int ST_S2   = 1;
  localparam int ST_PROD = FRAC_W + 2;
  localparam int ST_HALF = FRAC_W + 3;
  localparam int ST_SUM  = FRAC_W + 4;
  localparam int ST_OUT  = FRAC_W + 5;
  localparam int NS      = FRAC_W + 6;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] adv;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int i = 1; i < NS; i++) begin
      if (adv[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[ST_OUT];

  // Stage 1: sizes, corner sums and the log2 scaling of the size deltas.
  logic signed [COORD_W-1:0] ax1, ay1, ax2, ay2;
  logic signed [DELTA_W-1:0] dx, dy, dw, dh;
  st1_t s1_r, s1_nxt;

  assign ax1 = in_tdata[17:0];
  assign ay1 = in_tdata[35:18];
  assign ax2 = in_tdata[53:36];
  assign ay2 = in_tdata[71:54];
  assign dx  = in_tdata[87:72];
  assign dy  = in_tdata[103:88];
  assign dw  = in_tdata[119:104];
  assign dh  = in_tdata[135:120];

  always_comb begin
    s1_nxt.w  = SIZE_W'(ax2) - SIZE_W'(ax1) + SIZE_W'(16);
    s1_nxt.h  = SIZE_W'(ay2) - SIZE_W'(ay1) + SIZE_W'(16);
    s1_nxt.sx = SIZE_W'(ax1) + SIZE_W'(ax2) + SIZE_W'(16);
    s1_nxt.sy = SIZE_W'(ay1) + SIZE_W'(ay2) + SIZE_W'(16);
    s1_nxt.dx = dx;
    s1_nxt.dy = dy;
    s1_nxt.tw = SCL_W'(dw) * $signed(SCL_W'(LOG2E_Q16));
    s1_nxt.th = SCL_W'(dh) * $signed(SCL_W'(LOG2E_Q16));
  end

  always_ff @(posedge clk) begin
    if (adv[ST_S1]) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage 2: centre offsets, and the power of two rounded to Q.16 and split.
  st2_t s2_r, s2_nxt;
  logic signed [SCL_W:0] tbw, tbh;

  always_comb begin
    tbw        = $signed({s1_r.tw[SCL_W-1], s1_r.tw}) + $signed((SCL_W+1)'(2048));
    tbh        = $signed({s1_r.th[SCL_W-1], s1_r.th}) + $signed((SCL_W+1)'(2048));
    s2_nxt.w   = s1_r.w;
    s2_nxt.h   = s1_r.h;
    s2_nxt.sx  = s1_r.sx;
    s2_nxt.sy  = s1_r.sy;
    s2_nxt.dxw = PSH_W'(s1_r.dx) * PSH_W'(s1_r.w);
    s2_nxt.dyh = PSH_W'(s1_r.dy) * PSH_W'(s1_r.h);
    s2_nxt.iw  = tbw[32:28];
    s2_nxt.ih  = tbh[32:28];
    s2_nxt.fw  = tbw[27:12];
    s2_nxt.fh  = tbh[27:12];
  end

  always_ff @(posedge clk) begin
    if (adv[ST_S2]) begin
      s2_r <= s2_nxt;
    end
  end

  // Seed of the mantissa chain; the centres are finished alongside the first step.
  mant_t seed;

  always_comb begin
    seed.cx = $signed({{(CTR_W-SIZE_W-11){s2_r.sx[SIZE_W-1]}}, s2_r.sx, 11'b0})
            + $signed({s2_r.dxw[PSH_W-1], s2_r.dxw});
    seed.cy = $signed({{(CTR_W-SIZE_W-11){s2_r.sy[SIZE_W-1]}}, s2_r.sy, 11'b0})
            + $signed({s2_r.dyh[PSH_W-1], s2_r.dyh});
    seed.w  = s2_r.w;
    seed.h  = s2_r.h;
    seed.iw = s2_r.iw;
    seed.ih = s2_r.ih;
    seed.fw = s2_r.fw;
    seed.fh = s2_r.fh;
    seed.mw = MANT_W'(1) << 30;
    seed.mh = MANT_W'(1) << 30;
  end

  // Stages 3 to 18: one fraction bit per stage, most significant first.
  mant_t mst_r [1:FRAC_W];

  for (genvar k = 1; k <= FRAC_W; k++) begin : g_frac
    mant_t stin;
    mant_t mst_nxt;

    if (k == 1) begin : g_first
      assign stin = seed;
    end else begin : g_next
      assign stin = mst_r[k-1];
    end

    always_comb begin
      mst_nxt = stin;
      if (stin.fw[FRAC_W-k]) begin
        mst_nxt.mw = frac_step(stin.mw, pow2_frac(k));
      end
      if (stin.fh[FRAC_W-k]) begin
        mst_nxt.mh = frac_step(stin.mh, pow2_frac(k));
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k+1]) begin
        mst_r[k] <= mst_nxt;
      end
    end
  end

  // Stage 19: size times mantissa, and the rounding shift from the integer power.
  prod_t pr_r, pr_nxt;
  logic signed [SHAMT_W:0] shw_full, shh_full;

  always_comb begin
    shw_full   = $signed((SHAMT_W+1)'(19)) - $signed({mst_r[FRAC_W].iw[EXP_W-1],
                                                      mst_r[FRAC_W].iw});
    shh_full   = $signed((SHAMT_W+1)'(19)) - $signed({mst_r[FRAC_W].ih[EXP_W-1],
                                                      mst_r[FRAC_W].ih});
    pr_nxt.cx  = mst_r[FRAC_W].cx;
    pr_nxt.cy  = mst_r[FRAC_W].cy;
    pr_nxt.pw  = PROD_W'(mst_r[FRAC_W].w) * $signed(PROD_W'(mst_r[FRAC_W].mw));
    pr_nxt.ph  = PROD_W'(mst_r[FRAC_W].h) * $signed(PROD_W'(mst_r[FRAC_W].mh));
    pr_nxt.shw = shw_full[SHAMT_W-1:0];
    pr_nxt.shh = shh_full[SHAMT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[ST_PROD]) begin
      pr_r <= pr_nxt;
    end
  end

  // Stage 20: half of each scaled size, rounded half up at the variable shift.
  half_t hf_r, hf_nxt;
  logic [PROD_W:0]        rnd_w, rnd_h;
  logic signed [PROD_W:0] bw, bh, qw, qh;

  always_comb begin
    rnd_w     = (PROD_W+1)'(1) << (pr_r.shw - SHAMT_W'(1));
    rnd_h     = (PROD_W+1)'(1) << (pr_r.shh - SHAMT_W'(1));
    bw        = $signed({pr_r.pw[PROD_W-1], pr_r.pw}) + $signed(rnd_w);
    bh        = $signed({pr_r.ph[PROD_W-1], pr_r.ph}) + $signed(rnd_h);
    qw        = bw >>> pr_r.shw;
    qh        = bh >>> pr_r.shh;
    hf_nxt.cx = pr_r.cx;
    hf_nxt.cy = pr_r.cy;
    hf_nxt.hw = qw[HALF_W-1:0];
    hf_nxt.hh = qh[HALF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[ST_HALF]) begin
      hf_r <= hf_nxt;
    end
  end

  // Stage 21: corners as centre minus and plus half the scaled size.
  sum_t sm_r, sm_nxt;
  logic signed [SUM_W-1:0] cxe, cye, hwe, hhe;

  always_comb begin
    cxe       = SUM_W'(hf_r.cx);
    cye       = SUM_W'(hf_r.cy);
    hwe       = SUM_W'(hf_r.hw);
    hhe       = SUM_W'(hf_r.hh);
    sm_nxt.x1 = cxe - hwe;
    sm_nxt.y1 = cye - hhe;
    sm_nxt.x2 = cxe + hwe;
    sm_nxt.y2 = cye + hhe;
  end

  always_ff @(posedge clk) begin
    if (adv[ST_SUM]) begin
      sm_r <= sm_nxt;
    end
  end

  // Stage 22: round to Q14.4, clamp, and hold the output beat.
  logic signed [COORD_W-1:0] cx1, cy1, cx2, cy2;
  logic [3:0]                clamp;
  logic [71:0]               tdata_r, tdata_nxt;
  logic                      sat_r, sat_nxt;

  bdd_corner u_x1 (.v(sm_r.x1), .coord(cx1), .clamped(clamp[0]));
  bdd_corner u_y1 (.v(sm_r.y1), .coord(cy1), .clamped(clamp[1]));
  bdd_corner u_x2 (.v(sm_r.x2), .coord(cx2), .clamped(clamp[2]));
  bdd_corner u_y2 (.v(sm_r.y2), .coord(cy2), .clamped(clamp[3]));

  assign tdata_nxt = {cy2, cx2, cy1, cx1};
  assign sat_nxt   = |clamp;

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      tdata_r <= tdata_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_tdata = tdata_r;
  assign out_tuser = sat_r;

  // The input is refused only when every stage is full and the output beat is held.
  a_full_when_refused: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&vld_r) && !out_tready))
    else $error("input refused while the pipeline has an empty stage");

  // An item in the corner stage that cannot move is still there in the next cycle.
  a_sum_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_SUM] && !adv[ST_SUM]) |=> vld_r[ST_SUM])
    else $error("item lost from the corner stage during a stall");

  // A clamp flag always comes with at least one corner sitting on a range limit.
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      ($signed(out_tdata[17:0])  == COORD_MAX || $signed(out_tdata[17:0])  == COORD_MIN ||
       $signed(out_tdata[35:18]) == COORD_MAX || $signed(out_tdata[35:18]) == COORD_MIN ||
       $signed(out_tdata[53:36]) == COORD_MAX || $signed(out_tdata[53:36]) == COORD_MIN ||
       $signed(out_tdata[71:54]) == COORD_MAX || $signed(out_tdata[71:54]) == COORD_MIN))
    else $error("saturation flagged with no corner at a range limit");

endmodule

`default_nettype wire
